/* rtl/vrt_pkg.sv */
// shared types, constants and helpers of the velocity rescale thermostat
`timescale 1ns / 1ps

package vrt_pkg;

	localparam int DEF_MAX_PARTICLES = 1024;
	localparam int DEF_SPACE_DIMS    = 3;

	localparam logic [31:0] ONE_Q16       = 32'd65536;
	localparam logic [31:0] TEMP_RESET    = 32'd13107;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int SQ_X_W = 64;
	localparam int SQ_R_W = 32;

	localparam logic OP_ACCUMULATE = 1'b0;
	localparam logic OP_RESCALE    = 1'b1;

	localparam logic REG_TARGET_TEMP  = 1'b0;
	localparam logic REG_USE_SUPPLIED = 1'b1;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] event_time;
		logic signed [31:0] now_time;
		logic               immobile;
		logic               last_item;
		logic [47:0]        supplied_energy;
	} item_t;

	typedef struct packed {
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] sync_time;
		logic [31:0]        measured_temperature;
		logic               pass_done;
		logic               divide_fault;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_PREP,
		ST_DIV_TEMP,
		ST_DIV_FACT,
		ST_SQRT,
		ST_OUT
	} state_t;

	function automatic logic [31:0] sat_s32(input logic signed [PROD_W-1:0] x);
		if (x > $signed({{(PROD_W-31){1'b0}}, {31{1'b1}}})) begin
			return 32'h7FFF_FFFF;
		end else if (x < $signed({{(PROD_W-31){1'b1}}, {31{1'b0}}})) begin
			return 32'h8000_0000;
		end else begin
			return x[31:0];
		end
	endfunction

endpackage

/* rtl/vrt_mul.sv */
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module vrt_mul import vrt_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

/* rtl/vrt_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module vrt_div import vrt_pkg::*; #(
	parameter int NUM_W = 76,
	parameter int DEN_W = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CW = $clog2(NUM_W + 1);

	logic             busy_q, done_q;
	logic [CW-1:0]    cnt_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   r2, diff;
	logic             ge;

	// partial remainder with next numerator bit
	assign r2   = {rem_q, quo_q[NUM_W-1]};
	assign diff = r2 - {1'b0, den_q};
	assign ge   = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

/* rtl/vrt_sqrt.sv */
// digit-by-digit integer square root, two radicand bits per cycle
`timescale 1ns / 1ps

module vrt_sqrt import vrt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_X_W-1:0] x,
	output logic              done,
	output logic [SQ_R_W-1:0] root
);

	localparam int CW = $clog2(SQ_R_W);

	logic              busy_q, done_q;
	logic [CW-1:0]     cnt_q;
	logic [SQ_X_W-1:0] x_q, res_q, bit_q, trial;
	logic              ge;

	assign trial = res_q + bit_q;
	assign ge    = x_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(SQ_R_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			res_q <= '0;
			bit_q <= {2'b01, {(SQ_X_W-2){1'b0}}};
		end else if (busy_q) begin
			if (ge) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[SQ_R_W-1:0];

endmodule

/* rtl/velocity_rescale_thermostat.sv */
// top level of the two-pass velocity rescale thermostat
// usage:
//   items arrive on item/item_valid/item_stall, results leave on
//   result/result_valid/result_stall; an item moves when valid is high and
//   stall is low at a rising edge
//   operation accumulate: half squared speed and mobile count are summed;
//   only the item marked last_item gives a result (temperature, fault flag)
//   operation rescale: the particle is advanced to now_time and its velocity
//   is scaled by the factor found at the end of the last accumulate pass
// sequencing: one item at a time; item_stall is high while an item is at work
//   accumulate item: three passes through the shared multiplier
//   rescale item: six multiplier passes plus output load
//   last accumulate item: adds two runs of the bit-serial divider (temperature,
//   then factor) and a 32-step square root
// reset: arst_n clears sums and count, sets the factor to 1.0, target
//   temperature to 0.2 and energy source to the accumulated sum
// stall: a finished result waits in the output register; the next item is
//   still taken, and the sequencer holds its own result until the register frees
// config (apb, pready always high) is to be written by the user only while the
//   block is idle; the block itself does not enforce this
`timescale 1ns / 1ps

module velocity_rescale_thermostat import vrt_pkg::*; #(
	parameter int MAX_PARTICLES = DEF_MAX_PARTICLES,
	parameter int SPACE_DIMS    = DEF_SPACE_DIMS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        item_valid,
	output logic        item_stall,
	output result_t     result,
	output logic        result_valid,
	input  logic        result_stall,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
	localparam int ND_W  = CNT_W + 2;
	localparam int DIV_W = ND_W + 63;   // nd*T shifted left by 31

	// config registers
	logic [31:0] target_q;
	logic        use_sup_q;

	// sequencer state
	state_t state_q, state_d;
	logic [2:0] cnt_q;
	logic [2:0] nmul;
	logic [2:0] j;

	// working registers
	item_t              item_q;
	logic signed [32:0] dt_q;
	logic [63:0]        sq_q;
	logic [63:0]        sum_q;
	logic [CNT_W-1:0]   count_q;
	logic [31:0]        scale_q;
	logic [63:0]        e_q;
	logic [ND_W-1:0]    nd_q;
	result_t            res_q;
	result_t            out_q;
	logic               out_valid_q;

	// shared unit hookups
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic                     div_start, div_done;
	logic [DIV_W-1:0]         div_num, div_quot;
	logic [63:0]              div_den;
	logic                     sqrt_start, sqrt_done;
	logic [SQ_X_W-1:0]        sqrt_x;
	logic [SQ_R_W-1:0]        sqrt_root;

	// end-of-pass arithmetic
	logic [63:0]        half;
	logic [64:0]        sum_wide;
	logic [63:0]        sum_new;
	logic [CNT_W-1:0]   count_new;
	logic [63:0]        e_sel;
	logic [ND_W-1:0]    nd_new;
	logic               fault;
	logic signed [31:0] vel_sel;
	logic               out_free;

	assign item_stall   = state_q != ST_IDLE;
	assign result       = out_q;
	assign result_valid = out_valid_q;
	assign out_free     = !out_valid_q || !result_stall;
	assign pready       = 1'b1;

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= TEMP_RESET;
			use_sup_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_TARGET_TEMP:  target_q  <= pwdata;
				REG_USE_SUPPLIED: use_sup_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TARGET_TEMP:  prdata = target_q;
			REG_USE_SUPPLIED: prdata = {31'd0, use_sup_q};
			default:          prdata = '0;
		endcase
	end

	// shared units
	vrt_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	vrt_div #(
		.NUM_W (DIV_W),
		.DEN_W (64)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	vrt_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (sqrt_x),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// multiplier passes: three for accumulate, six for rescale
	assign nmul = (item_q.operation == OP_RESCALE) ? 3'd6 : 3'd3;
	assign j    = cnt_q - 3'd1;

	always_comb begin
		case (cnt_q)
			3'd0, 3'd3: vel_sel = item_q.vel_x;
			3'd1, 3'd4: vel_sel = item_q.vel_y;
			default:    vel_sel = item_q.vel_z;
		endcase
	end

	// energy sum and mobile count including the current item
	assign half      = sq_q >> 17;
	assign sum_wide  = {1'b0, sum_q} + {1'b0, half};
	assign sum_new   = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
	assign count_new = (!item_q.immobile && count_q < CNT_W'(MAX_PARTICLES))
	                   ? count_q + 1'b1 : count_q;
	assign e_sel     = use_sup_q ? {16'd0, item_q.supplied_energy} : sum_new;
	assign nd_new    = ND_W'(count_new) * ND_W'(SPACE_DIMS);
	assign fault     = (e_sel == '0) || (count_new == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (item_valid) state_d = ST_MUL;
			ST_MUL: begin
				if (cnt_q == nmul) begin
					state_d = (item_q.operation == OP_RESCALE) ? ST_OUT : ST_ACC;
				end
			end
			ST_ACC: begin
				if (!item_q.last_item) state_d = ST_IDLE;
				else if (fault)        state_d = ST_OUT;
				else                   state_d = ST_PREP;
			end
			ST_PREP:     state_d = ST_DIV_TEMP;
			ST_DIV_TEMP: if (div_done) state_d = ST_DIV_FACT;
			ST_DIV_FACT: if (div_done) state_d = ST_SQRT;
			ST_SQRT:     if (sqrt_done) state_d = ST_OUT;
			ST_OUT:      if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		// idle default keeps nd*T in the multiplier for the factor divide
		mul_a      = $signed({{(MUL_W-ND_W){1'b0}}, nd_q});
		mul_b      = $signed({1'b0, target_q});
		div_start  = 1'b0;
		div_num    = {prod[ND_W+31:0], 31'd0};
		div_den    = e_q;
		sqrt_start = 1'b0;
		sqrt_x     = (div_quot[DIV_W-1:64] != '0) ? {64{1'b1}} : div_quot[63:0];
		case (state_q)
			ST_MUL: begin
				mul_a = $signed({vel_sel[31], vel_sel});
				if (item_q.operation == OP_ACCUMULATE) begin
					mul_b = $signed({vel_sel[31], vel_sel});
				end else if (cnt_q < 3'd3) begin
					mul_b = dt_q;
				end else begin
					mul_b = $signed({1'b0, scale_q});
				end
			end
			ST_PREP: begin
				div_start = 1'b1;
				div_num   = {{(DIV_W-65){1'b0}}, e_q, 1'b0};
				div_den   = {{(64-ND_W){1'b0}}, nd_q};
			end
			ST_DIV_TEMP: div_start  = div_done;
			ST_DIV_FACT: sqrt_start = div_done;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			scale_q     <= ONE_Q16;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) cnt_q <= '0;
			else if (state_q == ST_MUL) cnt_q <= cnt_q + 1'b1;
			if (state_q == ST_ACC) begin
				if (item_q.last_item) begin
					sum_q   <= '0;
					count_q <= '0;
					if (fault) scale_q <= ONE_Q16;
				end else begin
					sum_q   <= sum_new;
					count_q <= count_new;
				end
			end
			if (state_q == ST_SQRT && sqrt_done) scale_q <= 32'(sqrt_root);
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_q <= item;
					dt_q   <= $signed({item.now_time[31], item.now_time})
					        - $signed({item.event_time[31], item.event_time});
					sq_q   <= '0;
					// only sync_time is known at intake, the rest starts at zero
					res_q  <= {192'd0, item.now_time, 34'd0};
				end
			end
			ST_MUL: begin
				if (cnt_q != 3'd0) begin
					if (item_q.operation == OP_ACCUMULATE) begin
						sq_q <= sq_q + prod[63:0];
					end else begin
						case (j)
							3'd0: res_q.new_pos_x <= sat_s32($signed({{(PROD_W-32)
							          {item_q.pos_x[31]}}, item_q.pos_x}) + (prod >>> 16));
							3'd1: res_q.new_pos_y <= sat_s32($signed({{(PROD_W-32)
							          {item_q.pos_y[31]}}, item_q.pos_y}) + (prod >>> 16));
							3'd2: res_q.new_pos_z <= sat_s32($signed({{(PROD_W-32)
							          {item_q.pos_z[31]}}, item_q.pos_z}) + (prod >>> 16));
							default: ;
						endcase
						case (cnt_q)
							3'd4: res_q.new_vel_x <= sat_s32(prod >>> 16);
							3'd5: res_q.new_vel_y <= sat_s32(prod >>> 16);
							3'd6: res_q.new_vel_z <= sat_s32(prod >>> 16);
							default: ;
						endcase
					end
				end
			end
			ST_ACC: begin
				e_q   <= e_sel;
				nd_q  <= nd_new;
				// pass end: everything zero except pass_done and the fault flag
				res_q <= {256'd0, 1'b1, fault};
			end
			ST_DIV_TEMP: begin
				if (div_done) begin
					res_q.measured_temperature <= (div_quot[DIV_W-1:32] != '0)
					                              ? 32'hFFFF_FFFF : div_quot[31:0];
				end
			end
			ST_OUT: if (out_free) out_q <= res_q;
			default: ;
		endcase
	end

endmodule
